// ===== sv/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, operation codes, stage types and rounding/saturation helpers
// for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int CMD_W     = 3;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int DEN_W     = PROD_W;
  localparam int NMAG_W    = PROD_W + FRAC_BITS;
  localparam int QBITS     = DATA_W;
  localparam int NHI_W     = NMAG_W - QBITS;
  localparam int ITERS     = DATA_W;
  localparam int SQREM_W   = DATA_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4
  } cmd_t;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    word_t value;
    logic  ov;
  } sat_t;

  // State carried through one iteration of the divide and square root units.
  typedef struct packed {
    logic                valid;
    logic [CMD_W-1:0]    cmd;
    word_t               simple_re;
    word_t               simple_im;
    logic                simple_ov;
    logic                dz;
    logic                neg_re;
    logic                neg_im;
    logic                big_re;
    logic                big_im;
    logic [DEN_W-1:0]    den;
    logic [DEN_W-1:0]    rem_re;
    logic [DEN_W-1:0]    rem_im;
    logic [QBITS-1:0]    low_re;
    logic [QBITS-1:0]    low_im;
    logic [QBITS-1:0]    q_re;
    logic [QBITS-1:0]    q_im;
    logic [PROD_W-1:0]   sq_n;
    logic [SQREM_W-1:0]  sq_rem;
    logic [DATA_W-1:0]   sq_root;
  } iter_t;

  typedef struct packed {
    word_t result_real;
    word_t result_imag;
    logic  overflow;
    logic  div_by_zero;
  } res_t;

  // Saturate a wide signed value to one data word.
  function automatic sat_t sat_wide(input logic signed [SUM_W-1:0] v);
    sat_t r;
    r.value = v[DATA_W-1:0];
    r.ov    = 1'b0;
    if (!v[SUM_W-1] && (|v[SUM_W-2:DATA_W-1])) begin
      r.value = WORD_MAX;
      r.ov    = 1'b1;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:DATA_W-1])) begin
      r.value = WORD_MIN;
      r.ov    = 1'b1;
    end
    return r;
  endfunction

  // Floor of a signed quotient from its magnitude quotient and remainder.
  function automatic sat_t sat_quot(input logic neg, input logic big,
                                    input logic [QBITS-1:0] q, input logic rnz);
    sat_t r;
    logic [QBITS:0] mag;
    mag     = {1'b0, q} + {{QBITS{1'b0}}, rnz};
    r.value = q;
    r.ov    = 1'b0;
    if (big) begin
      r.value = neg ? WORD_MIN : WORD_MAX;
      r.ov    = 1'b1;
    end else if (!neg) begin
      if (q[QBITS-1]) begin
        r.value = WORD_MAX;
        r.ov    = 1'b1;
      end
    end else if (mag > {1'b0, 1'b1, {(QBITS-1){1'b0}}}) begin
      r.value = WORD_MIN;
      r.ov    = 1'b1;
    end else begin
      r.value = word_t'(~mag[DATA_W-1:0] + 1'b1);
    end
    return r;
  endfunction

  function automatic sat_t sat_root(input logic [DATA_W-1:0] root);
    sat_t r;
    r.value = root;
    r.ov    = 1'b0;
    if (root[DATA_W-1]) begin
      r.value = WORD_MAX;
      r.ov    = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== sv/cau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_if
// Valid/ready channels for operation requests and results.
// ----------------------------------------------------------------------------
interface cau_in_if import cau_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  word_t            a_real;
  word_t            a_imag;
  word_t            b_real;
  word_t            b_imag;

  modport source (output valid, cmd, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, cmd, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if import cau_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t result_real;
  word_t result_imag;
  logic  overflow;
  logic  div_by_zero;

  modport source (output valid, result_real, result_imag, overflow, div_by_zero,
                  input ready);
  modport sink   (input valid, result_real, result_imag, overflow, div_by_zero,
                  output ready);
endinterface

// ===== sv/cau_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_iter
// One registered iteration: a restoring divide step for both quotient parts
// and a digit step of the integer square root.
// ----------------------------------------------------------------------------
module cau_iter import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  iter_t st_i,
  output iter_t st_o
);

  iter_t               st_r;
  iter_t               st_nxt;
  logic [DEN_W:0]      t_re;
  logic [DEN_W:0]      t_im;
  logic [DEN_W:0]      d_re;
  logic [DEN_W:0]      d_im;
  logic                ge_re;
  logic                ge_im;
  logic [SQREM_W+1:0]  sq_t;
  logic [SQREM_W+1:0]  sq_trial;
  logic [SQREM_W+1:0]  sq_d;
  logic                sq_ge;

  always_comb begin
    st_nxt = st_i;

    t_re  = {st_i.rem_re, st_i.low_re[QBITS-1]};
    t_im  = {st_i.rem_im, st_i.low_im[QBITS-1]};
    d_re  = t_re - {1'b0, st_i.den};
    d_im  = t_im - {1'b0, st_i.den};
    ge_re = t_re >= {1'b0, st_i.den};
    ge_im = t_im >= {1'b0, st_i.den};
    st_nxt.rem_re = ge_re ? d_re[DEN_W-1:0] : t_re[DEN_W-1:0];
    st_nxt.rem_im = ge_im ? d_im[DEN_W-1:0] : t_im[DEN_W-1:0];
    st_nxt.low_re = {st_i.low_re[QBITS-2:0], 1'b0};
    st_nxt.low_im = {st_i.low_im[QBITS-2:0], 1'b0};
    st_nxt.q_re   = {st_i.q_re[QBITS-2:0], ge_re};
    st_nxt.q_im   = {st_i.q_im[QBITS-2:0], ge_im};

    // Bring down two radicand bits and try appending a one to the root.
    sq_t     = {st_i.sq_rem, st_i.sq_n[PROD_W-1:PROD_W-2]};
    sq_trial = {2'b00, st_i.sq_root, 2'b01};
    sq_d     = sq_t - sq_trial;
    sq_ge    = sq_t >= sq_trial;
    st_nxt.sq_rem  = sq_ge ? sq_d[SQREM_W-1:0] : sq_t[SQREM_W-1:0];
    st_nxt.sq_root = {st_i.sq_root[DATA_W-2:0], sq_ge};
    st_nxt.sq_n    = {st_i.sq_n[PROD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

// ===== sv/complex_arith_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// Path: each transaction passes the operand, product, sum and set-up registers,
// then the 32 divide/square root steps and finally the output register.
// Throughput: one transaction per cycle; the pipeline stalls only when the
// output register and its skid entry are both full.
// Reset: synchronous, active low; clears every valid bit, payload is kept.
// ----------------------------------------------------------------------------
module complex_arith_unit import cau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  // The pipeline advances as a whole whenever the skid entry is empty, so an
  // accepted transaction can never be squeezed out by a stalled consumer.
  logic en;
  logic skid_valid_r;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  // Stage 1: registered operands. For the magnitude the first operand is also
  // routed to the second slot, so the shared multipliers form ar^2 and ai^2.
  logic             s1_valid_r;
  logic [CMD_W-1:0] s1_cmd_r;
  word_t            s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= in_ch.cmd;
      s1_ar_r  <= in_ch.a_real;
      s1_ai_r  <= in_ch.a_imag;
      s1_br_r  <= (in_ch.cmd == CMD_MAG) ? in_ch.a_real : in_ch.b_real;
      s1_bi_r  <= (in_ch.cmd == CMD_MAG) ? in_ch.a_imag : in_ch.b_imag;
    end
  end

  // Stage 2: six 32x32 products plus the add/subtract result.
  logic                     s2_valid_r;
  logic [CMD_W-1:0]         s2_cmd_r;
  logic signed [PROD_W-1:0] s2_rr_r, s2_ii_r, s2_ri_r, s2_ir_r, s2_dr_r, s2_di_r;
  logic signed [DATA_W:0]   s2_as_re_r, s2_as_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cmd_r <= s1_cmd_r;
      s2_rr_r  <= s1_ar_r * s1_br_r;
      s2_ii_r  <= s1_ai_r * s1_bi_r;
      s2_ri_r  <= s1_ar_r * s1_bi_r;
      s2_ir_r  <= s1_ai_r * s1_br_r;
      s2_dr_r  <= s1_br_r * s1_br_r;
      s2_di_r  <= s1_bi_r * s1_bi_r;
      if (s1_cmd_r == CMD_SUB) begin
        s2_as_re_r <= {s1_ar_r[DATA_W-1], s1_ar_r} - {s1_br_r[DATA_W-1], s1_br_r};
        s2_as_im_r <= {s1_ai_r[DATA_W-1], s1_ai_r} - {s1_bi_r[DATA_W-1], s1_bi_r};
      end else begin
        s2_as_re_r <= {s1_ar_r[DATA_W-1], s1_ar_r} + {s1_br_r[DATA_W-1], s1_br_r};
        s2_as_im_r <= {s1_ai_r[DATA_W-1], s1_ai_r} + {s1_bi_r[DATA_W-1], s1_bi_r};
      end
    end
  end

  // Stage 3: product sums. sum_a is the divide's real numerator and also the
  // squared magnitude; dif_b is the divide's imaginary numerator.
  logic signed [SUM_W-1:0] rr_x, ii_x, ri_x, ir_x;
  logic signed [SUM_W-1:0] dif_a, sum_b;
  logic signed [SUM_W-1:0] simple_re_nxt, simple_im_nxt;

  logic                    s3_valid_r;
  logic [CMD_W-1:0]        s3_cmd_r;
  logic signed [SUM_W-1:0] s3_sum_a_r, s3_dif_b_r, s3_simple_re_r, s3_simple_im_r;
  logic [DEN_W-1:0]        s3_den_r;

  always_comb begin
    rr_x  = {s2_rr_r[PROD_W-1], s2_rr_r};
    ii_x  = {s2_ii_r[PROD_W-1], s2_ii_r};
    ri_x  = {s2_ri_r[PROD_W-1], s2_ri_r};
    ir_x  = {s2_ir_r[PROD_W-1], s2_ir_r};
    dif_a = rr_x - ii_x;
    sum_b = ri_x + ir_x;
    simple_re_nxt = '0;
    simple_im_nxt = '0;
    case (s2_cmd_r)
      CMD_ADD, CMD_SUB: begin
        simple_re_nxt = {{(SUM_W-DATA_W-1){s2_as_re_r[DATA_W]}}, s2_as_re_r};
        simple_im_nxt = {{(SUM_W-DATA_W-1){s2_as_im_r[DATA_W]}}, s2_as_im_r};
      end
      CMD_MUL: begin
        simple_re_nxt = dif_a >>> FRAC_BITS;
        simple_im_nxt = sum_b >>> FRAC_BITS;
      end
      default: begin
        simple_re_nxt = '0;
        simple_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cmd_r       <= s2_cmd_r;
      s3_sum_a_r     <= rr_x + ii_x;
      s3_dif_b_r     <= ir_x - ri_x;
      s3_den_r       <= s2_dr_r + s2_di_r;
      s3_simple_re_r <= simple_re_nxt;
      s3_simple_im_r <= simple_im_nxt;
    end
  end

  // Stage 4: saturate the simple results and set up both dividers and the
  // square root. A quotient of 2^32 or more is flagged up front, so only the
  // low 32 quotient bits need to be developed by the iterations.
  iter_t              it [ITERS+1];
  iter_t              prep;
  sat_t               sat_re, sat_im;
  logic [PROD_W-1:0]  mag_re, mag_im;
  logic [NMAG_W-1:0]  nmag_re, nmag_im;
  logic [DEN_W-1:0]   hi_re, hi_im;

  always_comb begin
    sat_re  = sat_wide(s3_simple_re_r);
    sat_im  = sat_wide(s3_simple_im_r);
    mag_re  = s3_sum_a_r[SUM_W-1] ? PROD_W'(-s3_sum_a_r) : s3_sum_a_r[PROD_W-1:0];
    mag_im  = s3_dif_b_r[SUM_W-1] ? PROD_W'(-s3_dif_b_r) : s3_dif_b_r[PROD_W-1:0];
    nmag_re = {mag_re, {FRAC_BITS{1'b0}}};
    nmag_im = {mag_im, {FRAC_BITS{1'b0}}};
    hi_re   = DEN_W'(nmag_re[NMAG_W-1:QBITS]);
    hi_im   = DEN_W'(nmag_im[NMAG_W-1:QBITS]);

    prep           = '0;
    prep.valid     = s3_valid_r;
    prep.cmd       = s3_cmd_r;
    prep.simple_re = sat_re.value;
    prep.simple_im = sat_im.value;
    prep.simple_ov = sat_re.ov | sat_im.ov;
    prep.dz        = (s3_cmd_r == CMD_DIV) && (s3_den_r == '0);
    prep.neg_re    = s3_sum_a_r[SUM_W-1];
    prep.neg_im    = s3_dif_b_r[SUM_W-1];
    prep.big_re    = hi_re >= s3_den_r;
    prep.big_im    = hi_im >= s3_den_r;
    prep.den       = s3_den_r;
    prep.rem_re    = hi_re;
    prep.rem_im    = hi_im;
    prep.low_re    = nmag_re[QBITS-1:0];
    prep.low_im    = nmag_im[QBITS-1:0];
    prep.sq_n      = s3_sum_a_r[PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it[0].valid <= 1'b0;
    end else if (en) begin
      it[0] <= prep;
    end
  end

  // Stages 5 to 36: one quotient bit for each part and one root bit per step.
  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    cau_iter u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .st_i  (it[k]),
      .st_o  (it[k+1])
    );
  end

  // Final rounding and selection by operation.
  iter_t fin_st;
  res_t  fin;
  sat_t  q_re, q_im, root;
  logic  fin_v;

  always_comb begin
    fin_st = it[ITERS];
    fin_v  = en && fin_st.valid;
    q_re   = sat_quot(fin_st.neg_re, fin_st.big_re, fin_st.q_re, |fin_st.rem_re);
    q_im   = sat_quot(fin_st.neg_im, fin_st.big_im, fin_st.q_im, |fin_st.rem_im);
    root   = sat_root(fin_st.sq_root);
    fin    = '0;
    case (fin_st.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        fin.result_real = fin_st.simple_re;
        fin.result_imag = fin_st.simple_im;
        fin.overflow    = fin_st.simple_ov;
      end
      CMD_DIV: begin
        if (fin_st.dz) begin
          fin.div_by_zero = 1'b1;
        end else begin
          fin.result_real = q_re.value;
          fin.result_imag = q_im.value;
          fin.overflow    = q_re.ov | q_im.ov;
        end
      end
      CMD_MAG: begin
        fin.result_real = root.value;
        fin.overflow    = root.ov;
      end
      default: begin
        fin = '0;
      end
    endcase
  end

  // Output register with one skid entry behind it.
  logic out_valid_r;
  res_t out_r;
  res_t skid_r;
  logic out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= fin_v;
      end
    end else if (fin_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : fin;
    end
    if (!out_free && fin_v) begin
      skid_r <= fin;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_real = out_r.result_real;
  assign out_ch.result_imag = out_r.result_imag;
  assign out_ch.overflow    = out_r.overflow;
  assign out_ch.div_by_zero = out_r.div_by_zero;

  // The skid entry only fills behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // A held skid entry stays until the consumer takes the output transaction.
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("skid entry dropped while output stalled");

  // A zero divisor yields a clean zero result.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.div_by_zero) |->
      (out_r.result_real == '0 && out_r.result_imag == '0 && !out_r.overflow))
    else $error("divide by zero result not zero");

endmodule
